### design/ipspr_pkg.sv
// Package for the IPsec policy rule table: rule record type, table size,
// operation and status codes, and the low-bit helper. No dependencies.
package ipspr_pkg;

    localparam int RULE_SLOTS = 16;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;
    localparam logic [1:0] OP_FLUSH  = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOMATCH = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_NOSLOT  = 2'd3;

    localparam logic [8:0] PROTO_ANY = 9'd256;
    localparam logic [8:0] PROTO_TCP = 9'd6;
    localparam logic [8:0] PROTO_UDP = 9'd17;

    typedef struct packed {
        logic [31:0] src_addr;
        logic [31:0] src_netmask;
        logic [31:0] dst_addr;
        logic [31:0] dst_mask;
        logic [31:0] tunnel;
        logic [8:0]  proto;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [1:0]  action;
    } t_rule;

    // Command broadcast to every cell; it is held for the whole of an item.
    typedef struct packed {
        logic [1:0]  op;
        t_rule       rule;
        logic [1:0]  mode;
        logic        src_first;
    } t_cmd;

    // Index of lowest set bit, 32 when zero.
    function automatic logic [5:0] low_bit(input logic [31:0] m);
        logic [5:0] r;
        r = 6'd32;
        for (int i = 31; i >= 0; i--) begin
            if (m[i]) r = 6'(i);
        end
        return r;
    endfunction

endpackage

### design/ipspr_cell.sv
// One rule slot of the table: holds a rule, evaluates match and insert
// placement against the broadcast command, and shifts with its neighbors.
// Depends on ipspr_pkg.
module ipspr_cell
    import ipspr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_clear,
    input  t_cmd  i_cmd,
    input  logic  i_eval,
    input  logic  i_load_new,
    input  logic  i_load_prev,
    input  logic  i_load_next,
    input  t_rule i_prev,
    input  t_rule i_next,
    output t_rule o_rule,
    output logic  o_hit,
    output logic  o_place
);

    t_rule r_rule;
    logic  r_hit, r_place;
    logic  n_hit, n_place;
    t_rule init_rule;

    assign o_rule  = r_rule;
    assign o_hit   = r_hit;
    assign o_place = r_place;

    // Catch-all rule: everything zero, protocol any, bypass.
    always_comb begin
        init_rule       = '0;
        init_rule.proto = PROTO_ANY;
    end

    logic [5:0] k1, k2, e1, e2;
    logic [15:0] p1, p2, q1, q2;
    logic sm, dm, pm;

    always_comb begin
        k1 = low_bit(i_cmd.src_first ? i_cmd.rule.src_netmask : i_cmd.rule.dst_mask);
        k2 = low_bit(i_cmd.src_first ? i_cmd.rule.dst_mask : i_cmd.rule.src_netmask);
        e1 = low_bit(i_cmd.src_first ? r_rule.src_netmask : r_rule.dst_mask);
        e2 = low_bit(i_cmd.src_first ? r_rule.dst_mask : r_rule.src_netmask);
        p1 = i_cmd.src_first ? i_cmd.rule.sport : i_cmd.rule.dport;
        p2 = i_cmd.src_first ? i_cmd.rule.dport : i_cmd.rule.sport;
        q1 = i_cmd.src_first ? r_rule.sport : r_rule.dport;
        q2 = i_cmd.src_first ? r_rule.dport : r_rule.sport;
        n_place = (k1 < e1) ||
                  ((k1 == e1) && (k2 < e2)) ||
                  ((k1 == e1) && (k2 == e2) &&
                   (((p1 != 16'd0) && (q1 == 16'd0)) ||
                    ((p2 != 16'd0) && (q2 == 16'd0))));

        sm = i_cmd.mode[0] ||
             (((i_cmd.rule.src_addr ^ r_rule.src_addr) & r_rule.src_netmask) == 32'd0);
        dm = i_cmd.mode[1] ||
             (((i_cmd.rule.dst_addr ^ r_rule.dst_addr) & r_rule.dst_mask) == 32'd0);
        if (r_rule.proto == PROTO_ANY) begin
            pm = 1'b1;
        end else if (r_rule.proto != i_cmd.rule.proto) begin
            pm = 1'b0;
        end else if (i_cmd.rule.proto == PROTO_TCP || i_cmd.rule.proto == PROTO_UDP) begin
            pm = ((r_rule.sport == 16'd0) || (r_rule.sport == i_cmd.rule.sport)) &&
                 ((r_rule.dport == 16'd0) || (r_rule.dport == i_cmd.rule.dport));
        end else begin
            pm = 1'b1;
        end
        n_hit = sm && dm && pm;
    end

    always_ff @(posedge i_clk) begin
        if (i_eval) begin
            r_hit   <= n_hit;
            r_place <= n_place;
        end
        if (i_clear)          r_rule <= init_rule;
        else if (i_load_new)  r_rule <= i_cmd.rule;
        else if (i_load_prev) r_rule <= i_prev;
        else if (i_load_next) r_rule <= i_next;
    end

endmodule

### design/ipsec_policy_rule_table_top.sv
// Top level of the IPsec policy rule table: a chain of rule cells plus the
// control that sequences each operation. Depends on ipspr_pkg, ipspr_cell.
//
// Every operation runs in steps from its accepting edge to its result:
// the item is captured in the command register on the accepting edge; then
// all cells compare it against their rule in parallel and register hit and
// placement flags; then a priority pick over those flags sets the result and
// the cells shift one place toward or away from their neighbor (insert,
// delete) or slot 0 is rewritten (flush). The input stalls while an item is
// in progress and while a result waits under output stall, so a new item is
// taken only once the previous one has finished. After reset slot 0 holds the
// catch-all bypass rule and the table holds one rule.
module ipsec_policy_rule_table_top
    import ipspr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_operation,
    input  logic [31:0] i_src_addr,
    input  logic [31:0] i_src_netmask,
    input  logic [31:0] i_dst_addr,
    input  logic [31:0] i_dst_mask,
    input  logic [8:0]  i_protocol,
    input  logic [15:0] i_src_port,
    input  logic [15:0] i_dst_port,
    input  logic [1:0]  i_policy,
    input  logic [31:0] i_tunnel_dest,
    input  logic [1:0]  i_mode_flags,
    input  logic [3:0]  i_slot,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic        o_match_found,
    output logic [3:0]  o_match_slot,
    output logic [1:0]  o_match_policy,
    output logic [31:0] o_match_tunnel,
    output logic [4:0]  o_rule_total
);

    localparam int CW = $clog2(RULE_SLOTS + 1);
    localparam int IW = $clog2(RULE_SLOTS);

    t_cmd             r_cmd;
    logic [3:0]       r_slot;
    logic             r_busy;
    logic             r_eval;
    logic [CW-1:0]    r_count;
    logic             r_valid;
    logic [1:0]       r_status;
    logic             r_found;
    logic [3:0]       r_mslot;
    logic [1:0]       r_mpol;
    logic [31:0]      r_mtun;
    logic [4:0]       r_total;

    logic [1:0]       n_status;
    logic             n_found;
    logic [3:0]       n_mslot;
    logic [1:0]       n_mpol;
    logic [31:0]      n_mtun;
    logic [CW-1:0]    n_count;

    logic             accept;
    logic             fin;
    assign o_stall = r_busy || (r_valid && i_stall);
    assign accept  = i_valid && !o_stall;
    // Last cycle of an item: flags are settled, result and shifts happen now.
    assign fin     = r_busy && !r_eval;

    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_match_found  = r_found;
    assign o_match_slot   = r_mslot;
    assign o_match_policy = r_mpol;
    assign o_match_tunnel = r_mtun;
    assign o_rule_total   = r_total;

    t_cmd n_cmd;
    always_comb begin
        n_cmd.op               = i_operation;
        n_cmd.rule.src_addr    = i_src_addr;
        n_cmd.rule.src_netmask = i_src_netmask;
        n_cmd.rule.dst_addr    = i_dst_addr;
        n_cmd.rule.dst_mask    = i_dst_mask;
        n_cmd.rule.tunnel      = (i_operation == OP_FLUSH) ? 32'd0 : i_tunnel_dest;
        n_cmd.rule.proto       = i_protocol;
        n_cmd.rule.sport       = i_src_port;
        n_cmd.rule.dport       = i_dst_port;
        n_cmd.rule.action      = i_policy;
        n_cmd.mode             = i_mode_flags;
        n_cmd.src_first        = i_mode_flags[0];
    end

    t_rule cell_rule [RULE_SLOTS];
    logic [RULE_SLOTS-1:0] hit, place, valid_slot;
    logic [RULE_SLOTS-1:0] ld_new, ld_prev, ld_next;

    // Priority picks over registered flags, limited to slots in use.
    logic            any_hit, any_place;
    logic [IW-1:0]   hit_idx, place_idx;
    logic [CW-1:0]   pos;
    always_comb begin
        any_hit = 1'b0; any_place = 1'b0;
        hit_idx = '0; place_idx = '0;
        for (int i = RULE_SLOTS - 1; i >= 0; i--) begin
            valid_slot[i] = (CW'(i) < r_count);
            if (hit[i] && valid_slot[i]) begin
                any_hit = 1'b1; hit_idx = IW'(i);
            end
            if (place[i] && valid_slot[i]) begin
                any_place = 1'b1; place_idx = IW'(i);
            end
        end
        pos = any_place ? CW'(place_idx) : r_count;
    end

    logic full, bad_slot, do_ins, do_del;
    assign full     = (r_count == CW'(RULE_SLOTS));
    assign bad_slot = (CW'(r_slot) >= r_count);
    assign do_ins   = fin && (r_cmd.op == OP_INSERT) && !full;
    assign do_del   = fin && (r_cmd.op == OP_DELETE) && !bad_slot;

    always_comb begin
        for (int i = 0; i < RULE_SLOTS; i++) begin
            ld_new[i]  = (do_ins && CW'(i) == pos) ||
                         (fin && r_cmd.op == OP_FLUSH && i == 0);
            ld_prev[i] = do_ins && (CW'(i) > pos) && (CW'(i) <= r_count);
            ld_next[i] = do_del && (i >= 32'(r_slot)) && (i < RULE_SLOTS - 1);
        end
    end

    for (genvar g = 0; g < RULE_SLOTS; g++) begin : g_cell
        ipspr_cell u_cell (
            .i_clk       (i_clk),
            .i_clear     ((g == 0) && !i_rst_n),
            .i_cmd       (r_cmd),
            .i_eval      (r_eval),
            .i_load_new  (ld_new[g]),
            .i_load_prev (ld_prev[g]),
            .i_load_next (ld_next[g]),
            .i_prev      (cell_rule[(g == 0) ? 0 : g - 1]),
            .i_next      (cell_rule[(g == RULE_SLOTS - 1) ? g : g + 1]),
            .o_rule      (cell_rule[g]),
            .o_hit       (hit[g]),
            .o_place     (place[g])
        );
    end

    always_comb begin
        n_status = ST_OK;
        n_found  = 1'b0;
        n_mslot  = 4'd0;
        n_mpol   = 2'd0;
        n_mtun   = 32'd0;
        n_count  = r_count;
        unique case (r_cmd.op)
            OP_INSERT: begin
                if (full) n_status = ST_FULL;
                else begin
                    n_count = r_count + CW'(1);
                    n_mslot = 4'(pos);
                end
            end
            OP_LOOKUP: begin
                if (any_hit) begin
                    n_found = 1'b1;
                    n_mslot = 4'(hit_idx);
                    n_mpol  = cell_rule[hit_idx].action;
                    n_mtun  = cell_rule[hit_idx].tunnel;
                end else n_status = ST_NOMATCH;
            end
            OP_DELETE: begin
                if (bad_slot) n_status = ST_NOSLOT;
                else n_count = r_count - CW'(1);
            end
            default: begin
                n_count = CW'(1);
            end
        endcase
    end

    // Cells compare against the command register, so evaluation happens the
    // cycle after capture; flags are latched on that edge via r_eval.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_eval  <= 1'b0;
            r_valid <= 1'b0;
            r_count <= CW'(1);
        end else begin
            r_eval <= accept;
            if (accept) r_busy <= 1'b1;
            else if (fin) r_busy <= 1'b0;
            if (fin) r_valid <= 1'b1;
            else if (r_valid && !i_stall) r_valid <= 1'b0;
            if (fin) r_count <= n_count;
        end
        if (fin) begin
            r_status <= n_status;
            r_found  <= n_found;
            r_mslot  <= n_mslot;
            r_mpol   <= n_mpol;
            r_mtun   <= n_mtun;
            r_total  <= 5'(n_count);
        end
        if (accept) begin
            r_cmd  <= n_cmd;
            r_slot <= i_slot;
        end
    end

endmodule

### design/ipspr_checker.sv
// Port-level checker for the IPsec policy rule table, bound to the top level.
// Depends on ipspr_pkg.
module ipspr_checker
    import ipspr_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [1:0] o_status,
    input logic       o_match_found,
    input logic [3:0] o_match_slot,
    input logic [4:0] o_rule_total
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status))
        else $error("result dropped while stalled");

    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |-> o_stall)
        else $error("input taken while result is stalled");

    a_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_match_found |-> o_status == ST_OK)
        else $error("match with bad status");

    a_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_NOMATCH |-> o_match_slot == 4'd0)
        else $error("miss reports slot");

    a_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_rule_total <= 5'(RULE_SLOTS))
        else $error("rule total out of range");

endmodule

bind ipsec_policy_rule_table_top ipspr_checker u_checker (.*);
